@@ hdl/hgg_pkg.sv @@
// ----------------------------------------------------------------------------
// hgg_pkg
// shared types, widths and constants for the hexagonal-grid gaussian
// neighbourhood weight block
// ----------------------------------------------------------------------------
package hgg_pkg;

	// field widths
	localparam int OFS_W    = 6;
	localparam int CFG_W    = 24;
	localparam int WEIGHT_W = 17;

	// grid size; offsets at or beyond these magnitudes name no node
	localparam int GRID_ROWS = 32;
	localparam int GRID_COLS = 32;
	localparam int GRID_W    = 9;

	// squared distance in quarter units, (2c+s)^2 + 3r^2
	localparam int DIST_W = 13;
	// distance times inv_width_sq
	localparam int PROD_W = DIST_W + CFG_W;

	// exp(-x) evaluated as (exp(-x/16))^16 with a horner series in q0.32
	localparam int              HORNER_TERMS = 14;
	localparam int              SQUARINGS    = 4;
	localparam int              STEP_STAGES  = 3;
	localparam int              HORNER_ST    = HORNER_TERMS * STEP_STAGES;
	localparam int              LAST_ST      = HORNER_ST + SQUARINGS;
	localparam logic [32:0]     Q32_ONE      = 33'h1_0000_0000;
	localparam logic [PROD_W-1:0] CUTOFF_P   = PROD_W'(12 << 18);
	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(65536);

	// exact division of a 32-bit value by k: (t * DIV_MAGIC[k]) >> (32 + DIV_SHIFT[k])
	localparam logic [32:0] DIV_MAGIC [1:HORNER_TERMS] = '{
		33'h1_0000_0001, 33'h1_0000_0001, 33'h1_5555_5556, 33'h1_0000_0001,
		33'h1_9999_999A, 33'h1_5555_5556, 33'h1_2492_4925, 33'h1_0000_0001,
		33'h1_C71C_71C8, 33'h1_9999_999A, 33'h1_745D_1746, 33'h1_5555_5556,
		33'h1_3B13_B13C, 33'h1_2492_4925
	};
	localparam int DIV_SHIFT [1:HORNER_TERMS] = '{
		0, 1, 2, 2, 3, 3, 3, 3, 4, 4, 4, 4, 4, 4
	};

	// one classified request waiting between front and back
	typedef struct packed {
		logic              off_grid;
		logic [DIST_W-1:0] sq_quarters;
	} item_t;

endpackage

@@ hdl/hex_grid_gaussian_neighbourhood_top.sv @@
// ----------------------------------------------------------------------------
// hex_grid_gaussian_neighbourhood_top
// gaussian neighbourhood weight exp(-d^2 * inv_width_sq) on an offset-hex grid
// ----------------------------------------------------------------------------
// throughput: one request per cycle; the 14-term series and four squarings are fully
//   pipelined, so the queue never fills and busy stays low in normal use
// reset: arst_n clears the queue, all valid bits and the strobe, and sets
//   inv_width_sq to 2621; results are taken every strobe, the receiver cannot stall
module hex_grid_gaussian_neighbourhood_top (
	input  logic                                clk,
	input  logic                                arst_n,
	// request side
	input  logic                                start,
	output logic                                busy,
	input  logic signed [hgg_pkg::OFS_W-1:0]    row_offset,
	input  logic signed [hgg_pkg::OFS_W-1:0]    col_offset,
	input  logic                                target_row_odd,
	// width register
	input  logic                                cfg_wen,
	input  logic [hgg_pkg::CFG_W-1:0]           cfg_wdata,
	// result side
	output logic                                strobe,
	output logic [hgg_pkg::WEIGHT_W-1:0]        weight
);

	logic                      queue_full;
	logic                      queue_empty;
	logic                      push;
	hgg_pkg::item_t            push_item;
	hgg_pkg::item_t            head_item;
	logic [hgg_pkg::CFG_W-1:0] inv_width_sq_q;

	// reciprocal of width squared, unsigned q8.16; to be written only while idle, which the block itself does not enforce
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_width_sq_q <= hgg_pkg::CFG_W'(2621);
		end else if (cfg_wen) begin
			inv_width_sq_q <= cfg_wdata;
		end
	end

	// front: grid check and quarter-unit squared distance
	hgg_front u_front (
		.start          (start),
		.queue_full     (queue_full),
		.row_offset     (row_offset),
		.col_offset     (col_offset),
		.target_row_odd (target_row_odd),
		.busy           (busy),
		.push           (push),
		.item           (push_item)
	);

	// short queue lets the front keep accepting while the back is fed
	hgg_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (!queue_empty),
		.full      (queue_full),
		.empty     (queue_empty),
		.head      (head_item)
	);

	// back never stalls, so it drains the queue head every cycle
	hgg_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (!queue_empty),
		.in_item      (head_item),
		.inv_width_sq (inv_width_sq_q),
		.strobe       (strobe),
		.weight       (weight)
	);

endmodule

@@ hdl/hgg_front.sv @@
// ----------------------------------------------------------------------------
// hgg_front
// takes a request, checks it against the grid and forms the squared
// hexagonal distance in quarter units
// ----------------------------------------------------------------------------
module hgg_front (
	input  logic                             start,
	input  logic                             queue_full,
	input  logic signed [hgg_pkg::OFS_W-1:0] row_offset,
	input  logic signed [hgg_pkg::OFS_W-1:0] col_offset,
	input  logic                             target_row_odd,
	output logic                             busy,
	output logic                             push,
	output hgg_pkg::item_t                   item
);

	logic [hgg_pkg::OFS_W-1:0]        abs_row;
	logic [hgg_pkg::OFS_W-1:0]        abs_col;
	logic signed [hgg_pkg::OFS_W+1:0] col_x2;
	logic signed [hgg_pkg::OFS_W+1:0] col_adj;
	logic [hgg_pkg::OFS_W:0]          abs_adj;
	logic [2*hgg_pkg::OFS_W+1:0]      adj_sq;
	logic [2*hgg_pkg::OFS_W-1:0]      row_sq;
	logic [hgg_pkg::DIST_W-1:0]       row_sq3;

	assign busy = queue_full;
	assign push = start && !queue_full;

	// magnitudes; the most negative code gives the grid size itself
	assign abs_row = row_offset[hgg_pkg::OFS_W-1] ? hgg_pkg::OFS_W'(-row_offset) : row_offset;
	assign abs_col = col_offset[hgg_pkg::OFS_W-1] ? hgg_pkg::OFS_W'(-col_offset) : col_offset;

	// doubled column with the half-cell shift on odd row offsets
	assign col_x2 = {col_offset[hgg_pkg::OFS_W-1], col_offset, 1'b0};
	always_comb begin
		col_adj = col_x2;
		if (row_offset[0]) begin
			col_adj = target_row_odd ? col_x2 + 8'sd1 : col_x2 - 8'sd1;
		end
	end
	assign abs_adj = col_adj[hgg_pkg::OFS_W+1] ? (hgg_pkg::OFS_W+1)'(-col_adj)
	                                           : (hgg_pkg::OFS_W+1)'(col_adj);

	assign adj_sq  = abs_adj * abs_adj;
	assign row_sq  = abs_row * abs_row;
	assign row_sq3 = {row_sq, 1'b0} + {1'b0, row_sq};

	assign item.off_grid    = ({3'b000, abs_row} >= hgg_pkg::GRID_W'(hgg_pkg::GRID_ROWS))
	                       || ({3'b000, abs_col} >= hgg_pkg::GRID_W'(hgg_pkg::GRID_COLS));
	assign item.sq_quarters = hgg_pkg::DIST_W'(adj_sq) + row_sq3;

endmodule

@@ hdl/hgg_queue.sv @@
// ----------------------------------------------------------------------------
// hgg_queue
// four-entry fifo between front and back
// ----------------------------------------------------------------------------
module hgg_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  hgg_pkg::item_t push_item,
	input  logic           pop,
	output logic           full,
	output logic           empty,
	output hgg_pkg::item_t head
);

	hgg_pkg::item_t slot_q [0:3];
	logic [1:0]     wr_ptr_q;
	logic [1:0]     rd_ptr_q;
	logic [2:0]     count_q;
	logic           do_pop;

	assign full   = count_q == 3'd4;
	assign empty  = count_q == 3'd0;
	assign do_pop = pop && !empty;
	assign head   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 2'd1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + 3'd1;
				2'b01:   count_q <= count_q - 3'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ hdl/hgg_back.sv @@
// ----------------------------------------------------------------------------
// hgg_back
// scales the distance and evaluates exp(-x) in q1.16 through a fixed pipeline
// ----------------------------------------------------------------------------
module hgg_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  hgg_pkg::item_t                      in_item,
	input  logic [hgg_pkg::CFG_W-1:0]           inv_width_sq,
	output logic                                strobe,
	output logic [hgg_pkg::WEIGHT_W-1:0]        weight
);

	// scaled distance
	logic                        vld_s1;
	logic                        off_s1;
	logic [hgg_pkg::PROD_W-1:0]  p_s1;

	// side data running along the series and squaring stages
	logic                          vld_s  [0:hgg_pkg::LAST_ST];
	logic                          spec_s [0:hgg_pkg::LAST_ST];
	logic [hgg_pkg::WEIGHT_W-1:0]  specv_s[0:hgg_pkg::LAST_ST];
	logic [31:0]                   y_s    [0:hgg_pkg::HORNER_ST];

	// horner terms and squarings
	logic [32:0] e_s  [0:hgg_pkg::HORNER_TERMS];
	logic [31:0] sq_s [0:hgg_pkg::SQUARINGS];

	logic                         p_zero;
	logic                         p_big;
	logic [32:0]                  rnd_sum;
	logic                         strobe_q;
	logic [hgg_pkg::WEIGHT_W-1:0] weight_q;

	always_ff @(posedge clk) begin
		p_s1   <= hgg_pkg::PROD_W'(in_item.sq_quarters * inv_width_sq);
		off_s1 <= in_item.off_grid;
	end

	assign p_zero = p_s1 == '0;
	assign p_big  = p_s1 >= hgg_pkg::CUTOFF_P;

	// special outcomes are settled here and bypass the series
	always_ff @(posedge clk) begin
		spec_s[0]  <= off_s1 || p_zero || p_big;
		specv_s[0] <= (!off_s1 && p_zero) ? hgg_pkg::WEIGHT_ONE : '0;
		y_s[0]     <= {p_s1[21:0], 10'b0};
		e_s[0]     <= hgg_pkg::Q32_ONE;
		for (int n = 0; n < hgg_pkg::LAST_ST; n++) begin
			spec_s[n+1]  <= spec_s[n];
			specv_s[n+1] <= specv_s[n];
		end
		for (int n = 0; n < hgg_pkg::HORNER_ST; n++) begin
			y_s[n+1] <= y_s[n];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			for (int n = 0; n <= hgg_pkg::LAST_ST; n++) begin
				vld_s[n] <= 1'b0;
			end
		end else begin
			vld_s1   <= in_valid;
			vld_s[0] <= vld_s1;
			for (int n = 0; n < hgg_pkg::LAST_ST; n++) begin
				vld_s[n+1] <= vld_s[n];
			end
		end
	end

	// one series term per three stages: multiply, divide by k, subtract from one
	for (genvar j = 0; j < hgg_pkg::HORNER_TERMS; j++) begin : g_term
		localparam int K = hgg_pkg::HORNER_TERMS - j;
		logic [64:0] ye;
		logic [64:0] tm;
		logic [31:0] t_s;
		logic [31:0] quo_s;

		assign ye = {33'b0, y_s[j*hgg_pkg::STEP_STAGES]} * {32'b0, e_s[j]};
		assign tm = {33'b0, t_s} * {32'b0, hgg_pkg::DIV_MAGIC[K]};

		always_ff @(posedge clk) begin
			t_s      <= ye[63:32];
			quo_s    <= 32'(tm >> (32 + hgg_pkg::DIV_SHIFT[K]));
			e_s[j+1] <= hgg_pkg::Q32_ONE - {1'b0, quo_s};
		end
	end

	// raise to the sixteenth power
	assign sq_s[0] = e_s[hgg_pkg::HORNER_TERMS][31:0];
	for (genvar i = 0; i < hgg_pkg::SQUARINGS; i++) begin : g_sq
		logic [63:0] sq;
		assign sq = {32'b0, sq_s[i]} * {32'b0, sq_s[i]};
		always_ff @(posedge clk) begin
			sq_s[i+1] <= sq[63:32];
		end
	end

	assign rnd_sum = {1'b0, sq_s[hgg_pkg::SQUARINGS]} + 33'd32768;

	always_ff @(posedge clk) begin
		weight_q <= spec_s[hgg_pkg::LAST_ST] ? specv_s[hgg_pkg::LAST_ST] : rnd_sum[32:16];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= vld_s[hgg_pkg::LAST_ST];
		end
	end

	assign strobe = strobe_q;
	assign weight = weight_q;

endmodule
